@@ rtl/core/dva_pkg.sv @@
// ============================================================================
// dva_pkg
// Shared types, constants and tables for the date check and day offset block.
// ============================================================================
`default_nettype none

package dva_pkg;

    // Field widths
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned OFFSET_W = 17;
    localparam int unsigned STATUS_W = 3;

    // APB port
    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    // Day count from the shifted epoch (year 0 March 1 minus 400 years)
    localparam int unsigned DAYS_W  = 23;
    // Year with the January/February shift and the 400 year bias
    localparam int unsigned SYEAR_W = 15;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned DOE_W   = 18;
    localparam int unsigned ERA_W   = 6;
    localparam int unsigned YOE_W   = 9;

    localparam int unsigned YEAR_BIAS = 400;
    localparam int unsigned DAYS_ERA  = 146097;

    // Reset values of the configuration registers
    localparam logic [YEAR_W-1:0]  RST_MIN_YEAR    = 14'd1902;
    localparam logic [YEAR_W-1:0]  RST_MAX_YEAR    = 14'd2037;
    localparam logic [DAY_W-1:0]   RST_TODAY_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RST_TODAY_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RST_TODAY_YEAR  = 14'd2024;

    // Exact reciprocal constants: floor(x / C) = (x * MUL) >> SHIFT for x < 2**N,
    // with SHIFT = N + ceil(log2(C)) and MUL = ceil(2**SHIFT / C).
    localparam int unsigned DIV100_SHIFT = 22;   // N = 15
    localparam logic [15:0] DIV100_MUL =
        16'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

    localparam int unsigned DIV25_SHIFT = 19;    // N = 14
    localparam logic [14:0] DIV25_MUL =
        15'(((64'd1 << DIV25_SHIFT) + 64'd24) / 64'd25);

    localparam int unsigned DIVERA_SHIFT = 41;   // N = 23
    localparam logic [23:0] DIVERA_MUL =
        24'(((64'd1 << DIVERA_SHIFT) + 64'd146096) / 64'd146097);

    localparam int unsigned DIV1460_SHIFT = 29;  // N = 18
    localparam logic [18:0] DIV1460_MUL =
        19'(((64'd1 << DIV1460_SHIFT) + 64'd1459) / 64'd1460);

    localparam int unsigned DIV365_SHIFT = 27;   // N = 18
    localparam logic [18:0] DIV365_MUL =
        19'(((64'd1 << DIV365_SHIFT) + 64'd364) / 64'd365);

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_DAY   = 3'd1,
        ST_BAD_MONTH = 3'd2,
        ST_BAD_YEAR  = 3'd3,
        ST_NOT_LEAP  = 3'd4
    } status_t;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_MIN_YEAR    = 3'd0,
        REG_MAX_YEAR    = 3'd1,
        REG_TODAY_DAY   = 3'd2,
        REG_TODAY_MONTH = 3'd3,
        REG_TODAY_YEAR  = 3'd4
    } reg_idx_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [YEAR_W-1:0]  min_year;
        logic [YEAR_W-1:0]  max_year;
        logic [DAY_W-1:0]   today_day;
        logic [MONTH_W-1:0] today_month;
        logic [YEAR_W-1:0]  today_year;
    } cfg_t;

    // Word passed from the forward half to the inverse half
    typedef struct packed {
        status_t           status;
        logic [DAYS_W-1:0] days;
    } fwd_word_t;

    // Days in month 1..12, February allows 29
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = 5'd29;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // First day of month index (0 = March .. 11 = February) in a March-based year
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mi);
        logic [DOY_W-1:0] st;
        case (mi)
            4'd0:    st = 9'd0;
            4'd1:    st = 9'd31;
            4'd2:    st = 9'd61;
            4'd3:    st = 9'd92;
            4'd4:    st = 9'd122;
            4'd5:    st = 9'd153;
            4'd6:    st = 9'd184;
            4'd7:    st = 9'd214;
            4'd8:    st = 9'd245;
            4'd9:    st = 9'd275;
            4'd10:   st = 9'd306;
            4'd11:   st = 9'd337;
            default: st = 9'd0;
        endcase
        return st;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dva_req_if.sv @@
// ============================================================================
// dva_req_if
// Input channel: one date word plus a signed day offset.
// ============================================================================
`default_nettype none

interface dva_req_if
    import dva_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [DAY_W-1:0]           in_day;
    logic [MONTH_W-1:0]         in_month;
    logic [YEAR_W-1:0]          in_year;
    logic signed [OFFSET_W-1:0] day_offset;

    modport source (
        output valid, in_day, in_month, in_year, day_offset,
        input  ready
    );

    modport sink (
        input  valid, in_day, in_month, in_year, day_offset,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/dva_rsp_if.sv @@
// ============================================================================
// dva_rsp_if
// Output channel: normalized date and status.
// ============================================================================
`default_nettype none

interface dva_rsp_if
    import dva_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DAY_W-1:0]    out_day;
    logic [MONTH_W-1:0]  out_month;
    logic [YEAR_W-1:0]   out_year;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, out_day, out_month, out_year, status,
        input  ready
    );

    modport sink (
        input  valid, out_day, out_month, out_year, status,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/dva_regs.sv @@
// ============================================================================
// dva_regs
// APB configuration registers: year limits and today's date.
// ============================================================================
`default_nettype none

module dva_regs
    import dva_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_year    <= RST_MIN_YEAR;
            cfg_reg.max_year    <= RST_MAX_YEAR;
            cfg_reg.today_day   <= RST_TODAY_DAY;
            cfg_reg.today_month <= RST_TODAY_MONTH;
            cfg_reg.today_year  <= RST_TODAY_YEAR;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MIN_YEAR:    cfg_reg.min_year    <= pwdata[YEAR_W-1:0];
                REG_MAX_YEAR:    cfg_reg.max_year    <= pwdata[YEAR_W-1:0];
                REG_TODAY_DAY:   cfg_reg.today_day   <= pwdata[DAY_W-1:0];
                REG_TODAY_MONTH: cfg_reg.today_month <= pwdata[MONTH_W-1:0];
                REG_TODAY_YEAR:  cfg_reg.today_year  <= pwdata[YEAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_MIN_YEAR:    prdata = APB_DW'(cfg_reg.min_year);
            REG_MAX_YEAR:    prdata = APB_DW'(cfg_reg.max_year);
            REG_TODAY_DAY:   prdata = APB_DW'(cfg_reg.today_day);
            REG_TODAY_MONTH: prdata = APB_DW'(cfg_reg.today_month);
            REG_TODAY_YEAR:  prdata = APB_DW'(cfg_reg.today_year);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/dva_fwd.sv @@
// ============================================================================
// dva_fwd
// Front half: today substitution, date checks, date to day count.
// Three register stages.
// ============================================================================
`default_nettype none

module dva_fwd
    import dva_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    dva_req_if.sink    req,
    output logic       dn_valid,
    input  wire logic  dn_ready,
    output fwd_word_t  dn_word
);

    // Stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3      = !v3_reg || dn_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req.ready = rdy1;
    assign dn_valid  = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= req.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // ---------------- Stage 1: substitution and range checks ----------------
    logic [DAY_W-1:0]           d;
    logic [MONTH_W-1:0]         m;
    logic [YEAR_W-1:0]          y;
    logic [3:0]                 mi;
    status_t                    s1_status_next;
    logic [SYEAR_W-1:0]         s1_yp_next;
    logic [DOY_W-1:0]           s1_doy_next;
    logic                       s1_feb29_next;

    status_t                    s1_status_reg;
    logic [SYEAR_W-1:0]         s1_yp_reg;
    logic [DOY_W-1:0]           s1_doy_reg;
    logic [YEAR_W-1:0]          s1_y_reg;
    logic                       s1_feb29_reg;
    logic signed [OFFSET_W-1:0] s1_off_reg;

    always_comb
    begin
        d = (req.in_day   == '0) ? cfg.today_day   : req.in_day;
        m = (req.in_month == '0) ? cfg.today_month : req.in_month;
        y = (req.in_year  == '0) ? cfg.today_year  : req.in_year;

        // month, then day, then year; leap check follows later
        if (m < 4'd1 || m > 4'd12)
            s1_status_next = ST_BAD_MONTH;
        else if (d < 5'd1 || d > month_len(m))
            s1_status_next = ST_BAD_DAY;
        else if (y < cfg.min_year || y > cfg.max_year)
            s1_status_next = ST_BAD_YEAR;
        else
            s1_status_next = ST_OK;

        s1_feb29_next = (d == 5'd29) && (m == 4'd2);

        // March-based year: January and February belong to the year before
        mi          = (m > 4'd2) ? 4'(m - 4'd3) : 4'(m + 4'd9);
        s1_yp_next  = (m > 4'd2) ? SYEAR_W'(y) + SYEAR_W'(YEAR_BIAS)
                                 : SYEAR_W'(y) + SYEAR_W'(YEAR_BIAS - 1);
        s1_doy_next = month_start(mi) + DOY_W'(d) - DOY_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_status_reg <= s1_status_next;
            s1_yp_reg     <= s1_yp_next;
            s1_doy_reg    <= s1_doy_next;
            s1_y_reg      <= y;
            s1_feb29_reg  <= s1_feb29_next;
            s1_off_reg    <= req.day_offset;
        end
    end

    // ---------------- Stage 2: century and divisor-by-25 quotients ----------------
    logic [30:0]                prod100;
    logic [28:0]                prod25;
    logic [7:0]                 s2_q100_next;
    logic [9:0]                 s2_q25_next;

    status_t                    s2_status_reg;
    logic [SYEAR_W-1:0]         s2_yp_reg;
    logic [DOY_W-1:0]           s2_doy_reg;
    logic [YEAR_W-1:0]          s2_y_reg;
    logic                       s2_feb29_reg;
    logic signed [OFFSET_W-1:0] s2_off_reg;
    logic [7:0]                 s2_q100_reg;
    logic [9:0]                 s2_q25_reg;

    always_comb
    begin
        prod100      = 31'(s1_yp_reg) * 31'(DIV100_MUL);
        prod25       = 29'(s1_y_reg)  * 29'(DIV25_MUL);
        s2_q100_next = 8'(prod100 >> DIV100_SHIFT);
        s2_q25_next  = 10'(prod25 >> DIV25_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_status_reg <= s1_status_reg;
            s2_yp_reg     <= s1_yp_reg;
            s2_doy_reg    <= s1_doy_reg;
            s2_y_reg      <= s1_y_reg;
            s2_feb29_reg  <= s1_feb29_reg;
            s2_off_reg    <= s1_off_reg;
            s2_q100_reg   <= s2_q100_next;
            s2_q25_reg    <= s2_q25_next;
        end
    end

    // ---------------- Stage 3: leap check and day count ----------------
    logic               is_leap;
    logic               div25;
    logic [23:0]        base;
    logic signed [24:0] sum;
    status_t            s3_status_next;

    status_t            s3_status_reg;
    logic [DAYS_W-1:0]  s3_days_reg;

    always_comb
    begin
        // divisible by 4 and by 25 means a century year: leap only if by 16 too
        div25   = (14'(s2_q25_reg) * 14'd25) == s2_y_reg;
        is_leap = (s2_y_reg[1:0] == 2'b00) && (!div25 || (s2_y_reg[3:0] == 4'b0000));

        if (s2_status_reg == ST_OK && s2_feb29_reg && !is_leap)
            s3_status_next = ST_NOT_LEAP;
        else
            s3_status_next = s2_status_reg;

        base = 24'(s2_yp_reg) * 24'd365 + 24'(s2_yp_reg >> 2)
             + 24'(s2_q100_reg >> 2) - 24'(s2_q100_reg) + 24'(s2_doy_reg);
        sum  = $signed({1'b0, base}) + 25'(s2_off_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_status_reg <= s3_status_next;
            s3_days_reg   <= sum[DAYS_W-1:0];
        end
    end

    assign dn_word.status = s3_status_reg;
    assign dn_word.days   = s3_days_reg;

endmodule

`default_nettype wire

@@ rtl/core/dva_inv.sv @@
// ============================================================================
// dva_inv
// Back half: day count to date, result year check, output register.
// Six register stages, the last one drives the response channel.
// ============================================================================
`default_nettype none

module dva_inv
    import dva_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire fwd_word_t up_word,
    dva_rsp_if.source      rsp
);

    localparam int unsigned NSTG = 6;

    // Stage valids and ready chain
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] rdy;

    always_comb
    begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || rsp.ready;
        for (int k = NSTG - 2; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign up_ready  = rdy[0];
    assign rsp.valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= up_valid;
            for (int k = 1; k < NSTG; k++)
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // ---------------- Stage 1: 400 year era ----------------
    logic [46:0]       prod_era;
    status_t           s1_status_reg;
    logic [DAYS_W-1:0] s1_days_reg;
    logic [ERA_W-1:0]  s1_era_reg;

    assign prod_era = 47'(up_word.days) * 47'(DIVERA_MUL);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_status_reg <= up_word.status;
            s1_days_reg   <= up_word.days;
            s1_era_reg    <= ERA_W'(prod_era >> DIVERA_SHIFT);
        end
    end

    // ---------------- Stage 2: day of era ----------------
    logic [DAYS_W-1:0] era_days;
    status_t           s2_status_reg;
    logic [DOE_W-1:0]  s2_doe_reg;
    logic [ERA_W-1:0]  s2_era_reg;

    assign era_days = DAYS_W'(s1_era_reg) * DAYS_W'(DAYS_ERA);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s2_status_reg <= s1_status_reg;
            s2_doe_reg    <= DOE_W'(s1_days_reg - era_days);
            s2_era_reg    <= s1_era_reg;
        end
    end

    // ---------------- Stage 3: leap day correction within the era ----------------
    logic [36:0]      prod1460;
    logic [6:0]       q1460;
    logic [2:0]       q36524;
    logic             q146096;
    status_t          s3_status_reg;
    logic [DOE_W-1:0] s3_adj_reg;
    logic [DOE_W-1:0] s3_doe_reg;
    logic [ERA_W-1:0] s3_era_reg;

    always_comb
    begin
        prod1460 = 37'(s2_doe_reg) * 37'(DIV1460_MUL);
        q1460    = 7'(prod1460 >> DIV1460_SHIFT);
        // quotient by 36524 is at most 4: plain compares
        q36524   = 3'(s2_doe_reg >= 18'd36524) + 3'(s2_doe_reg >= 18'd73048)
                 + 3'(s2_doe_reg >= 18'd109572) + 3'(s2_doe_reg >= 18'd146096);
        q146096  = (s2_doe_reg >= 18'd146096);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s3_status_reg <= s2_status_reg;
            s3_adj_reg    <= s2_doe_reg - DOE_W'(q1460) + DOE_W'(q36524)
                           - DOE_W'(q146096);
            s3_doe_reg    <= s2_doe_reg;
            s3_era_reg    <= s2_era_reg;
        end
    end

    // ---------------- Stage 4: year of era ----------------
    logic [36:0]      prod365;
    status_t          s4_status_reg;
    logic [YOE_W-1:0] s4_yoe_reg;
    logic [DOE_W-1:0] s4_doe_reg;
    logic [ERA_W-1:0] s4_era_reg;

    assign prod365 = 37'(s3_adj_reg) * 37'(DIV365_MUL);

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s4_status_reg <= s3_status_reg;
            s4_yoe_reg    <= YOE_W'(prod365 >> DIV365_SHIFT);
            s4_doe_reg    <= s3_doe_reg;
            s4_era_reg    <= s3_era_reg;
        end
    end

    // ---------------- Stage 5: day of year and full shifted year ----------------
    logic [1:0]         c100;
    logic [DOE_W-1:0]   year_days;
    status_t            s5_status_reg;
    logic [DOY_W-1:0]   s5_doy_reg;
    logic [SYEAR_W-1:0] s5_yp_reg;

    always_comb
    begin
        c100 = 2'(s4_yoe_reg >= 9'd100) + 2'(s4_yoe_reg >= 9'd200)
             + 2'(s4_yoe_reg >= 9'd300);
        year_days = DOE_W'(s4_yoe_reg) * DOE_W'(365) + DOE_W'(s4_yoe_reg >> 2)
                  - DOE_W'(c100);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s5_status_reg <= s4_status_reg;
            s5_doy_reg    <= DOY_W'(s4_doe_reg - year_days);
            s5_yp_reg     <= SYEAR_W'(s4_era_reg) * SYEAR_W'(YEAR_BIAS)
                           + SYEAR_W'(s4_yoe_reg);
        end
    end

    // ---------------- Stage 6: month, day, year limits, output ----------------
    logic [3:0]          mp;
    logic [DAY_W-1:0]    rd;
    logic [MONTH_W-1:0]  rm;
    logic signed [15:0]  ry;
    logic                year_bad;
    status_t             st_next;

    logic [DAY_W-1:0]    out_day_reg;
    logic [MONTH_W-1:0]  out_month_reg;
    logic [YEAR_W-1:0]   out_year_reg;
    status_t             status_reg;

    always_comb
    begin
        // month index: count of month starts at or below the day of year
        mp = '0;
        for (int k = 1; k < 12; k++)
            mp = mp + 4'(s5_doy_reg >= month_start(4'(k)));

        rd = DAY_W'(s5_doy_reg - month_start(mp) + DOY_W'(1));
        rm = (mp < 4'd10) ? 4'(mp + 4'd3) : 4'(mp - 4'd9);
        ry = $signed({1'b0, s5_yp_reg}) + 16'(rm <= 4'd2) - 16'sd400;

        year_bad = (ry < $signed({2'b00, cfg.min_year}))
                || (ry > $signed({2'b00, cfg.max_year}));

        if (s5_status_reg != ST_OK)
            st_next = s5_status_reg;
        else if (year_bad)
            st_next = ST_BAD_YEAR;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            status_reg <= st_next;
            if (st_next == ST_OK)
            begin
                out_day_reg   <= rd;
                out_month_reg <= rm;
                out_year_reg  <= ry[YEAR_W-1:0];
            end
            else
            begin
                out_day_reg   <= '0;
                out_month_reg <= '0;
                out_year_reg  <= '0;
            end
        end
    end

    assign rsp.out_day   = out_day_reg;
    assign rsp.out_month = out_month_reg;
    assign rsp.out_year  = out_year_reg;
    assign rsp.status    = status_reg;

endmodule

`default_nettype wire

@@ rtl/core/date_validate_add_days.sv @@
// ============================================================================
// date_validate_add_days
// Gregorian date check with signed day offset, fully pipelined.
// ============================================================================
//
//  Channel  | Kind        | Word / access
//  ---------+-------------+------------------------------------------------
//  req      | valid/ready | in_day, in_month, in_year, day_offset
//  rsp      | valid/ready | out_day, out_month, out_year, status
//  apb      | APB slave   | 5 regs at byte address 4*i, 32 bit data
//
//  One word is accepted per cycle while the output is not stalled; from accept to
//  result valid there are 3 stages of check and day count and 6 stages of day count to date.
//  The widest step is the 23 x 24 bit era quotient multiply.
//  Reset clears all stage valid bits and loads the register reset values.
//  Each stage holds while its successor is full and stalled, so bubbles close
//  up and a stalled output still lets earlier stages fill.
//
`default_nettype none

module date_validate_add_days
    import dva_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    dva_req_if.sink                req,
    dva_rsp_if.source              rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    cfg_t      cfg;
    logic      mid_valid;
    logic      mid_ready;
    fwd_word_t mid_word;

    // Configuration registers
    dva_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Checks and date to day count
    dva_fwd u_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req      (req),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .dn_word  (mid_word)
    );

    // Day count to date and output register
    dva_inv u_inv (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (mid_valid),
        .up_ready (mid_ready),
        .up_word  (mid_word),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

@@ sim/date_validate_add_days_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// date_validate_add_days_tb
// Drives date words with signed day offsets through the block, predicts each
// normalized date and status in a scoreboard, and compares the results in
// order. Runs several register settings, with bursty input traffic and an
// output side that stalls on its own pattern.
// ============================================================================

module date_validate_add_days_tb;
    import dva_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_REGS    = 5;
    localparam int MAX_PRINTS  = 40;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 20;
    localparam int YEAR_TOP    = 16383;

    // Days per month, February counted as 29
    localparam int MONTH_DAYS [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [DAY_W-1:0]           day;
        logic [MONTH_W-1:0]         month;
        logic [YEAR_W-1:0]          year;
        logic signed [OFFSET_W-1:0] offset;
    } date_req_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        status_t            status;
    } date_rsp_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register copy, date predictor and queue of expected words
    // ------------------------------------------------------------------------
    class date_scoreboard;
        logic [YEAR_W-1:0]  min_year;
        logic [YEAR_W-1:0]  max_year;
        logic [DAY_W-1:0]   today_day;
        logic [MONTH_W-1:0] today_month;
        logic [YEAR_W-1:0]  today_year;
        date_rsp_t          expected_dates[$];
        int                 errors;
        int                 results_seen;

        function new();
            min_year     = RST_MIN_YEAR;
            max_year     = RST_MAX_YEAR;
            today_day    = RST_TODAY_DAY;
            today_month  = RST_TODAY_MONTH;
            today_year   = RST_TODAY_YEAR;
            errors       = 0;
            results_seen = 0;
        endfunction

        // Indexes past the last register are dropped
        function void write_register(logic [2:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_MIN_YEAR:    min_year    = value[YEAR_W-1:0];
                REG_MAX_YEAR:    max_year    = value[YEAR_W-1:0];
                REG_TODAY_DAY:   today_day   = value[DAY_W-1:0];
                REG_TODAY_MONTH: today_month = value[MONTH_W-1:0];
                REG_TODAY_YEAR:  today_year  = value[YEAR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit leap_year(longint y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // Day number relative to 1970-01-01, 400-year cycles, March-based year
        function longint day_number(longint y, longint m, longint d);
            longint cycle, yic, dy, dc;
            if (m <= 2)
                y = y - 1;
            cycle = ((y >= 0) ? y : y - 399) / 400;
            yic   = y - cycle * 400;
            dy    = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
            dc    = yic * 365 + yic / 4 - yic / 100 + dy;
            return cycle * 146097 + dc - 719468;
        endfunction

        function void civil_date(longint z, output longint y, output longint m,
                                 output longint d);
            longint cycle, dc, yic, dy, mp;
            z     = z + 719468;
            cycle = ((z >= 0) ? z : z - 146096) / 146097;
            dc    = z - cycle * 146097;
            yic   = (dc - dc / 1460 + dc / 36524 - dc / 146096) / 365;
            dy    = dc - (365 * yic + yic / 4 - yic / 100);
            mp    = (5 * dy + 2) / 153;
            d     = dy - (153 * mp + 2) / 5 + 1;
            m     = (mp < 10) ? mp + 3 : mp - 9;
            y     = yic + cycle * 400 + ((m <= 2) ? 1 : 0);
        endfunction

        // Substitute today, check month/day/year/leap, then shift by the offset
        function date_rsp_t shift_date(date_req_t w);
            longint    d, m, y, off, lo, hi, ry, rm, rd;
            status_t   st;
            date_rsp_t r;
            d   = (w.day   == '0) ? longint'(today_day)   : longint'(w.day);
            m   = (w.month == '0) ? longint'(today_month) : longint'(w.month);
            y   = (w.year  == '0) ? longint'(today_year)  : longint'(w.year);
            off = longint'($signed(w.offset));
            lo  = longint'(min_year);
            hi  = longint'(max_year);
            ry  = 0;
            rm  = 0;
            rd  = 0;
            st  = ST_OK;
            if (m < 1 || m > 12)
                st = ST_BAD_MONTH;
            else if (d < 1 || d > MONTH_DAYS[m - 1])
                st = ST_BAD_DAY;
            else if (y < lo || y > hi)
                st = ST_BAD_YEAR;
            else if (d == 29 && m == 2 && !leap_year(y))
                st = ST_NOT_LEAP;
            else
            begin
                civil_date(day_number(y, m, d) + off, ry, rm, rd);
                if (ry < lo || ry > hi || ry < 0 || ry > YEAR_TOP)
                    st = ST_BAD_YEAR;
            end
            if (st != ST_OK)
            begin
                ry = 0;
                rm = 0;
                rd = 0;
            end
            r.day    = rd[DAY_W-1:0];
            r.month  = rm[MONTH_W-1:0];
            r.year   = ry[YEAR_W-1:0];
            r.status = st;
            return r;
        endfunction

        function void note_request(date_req_t w);
            expected_dates.push_back(shift_date(w));
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
            errors++;
        endtask

        task check_result(date_rsp_t got);
            date_rsp_t want;
            results_seen++;
            if (expected_dates.size() == 0)
            begin
                report($sformatf("unexpected word %0d-%0d-%0d status %0d",
                                 got.year, got.month, got.day, got.status));
                return;
            end
            want = expected_dates.pop_front();
            if (got.day !== want.day)
                report($sformatf("out_day %0d, want %0d", got.day, want.day));
            if (got.month !== want.month)
                report($sformatf("out_month %0d, want %0d", got.month, want.month));
            if (got.year !== want.year)
                report($sformatf("out_year %0d, want %0d", got.year, want.year));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %s", got.status, want.status.name()));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    wire  [APB_DW-1:0]  prdata;
    wire                pready;
    int                 hold_off_cycles = 0;
    int                 cycle_count;
    date_scoreboard     board = new();

    dva_req_if req_ch ();
    dva_rsp_if rsp_ch ();

    date_validate_add_days dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one word from a falling edge, hold it until accepted
    task automatic drive_word(date_req_t w);
        req_ch.valid      <= 1'b1;
        req_ch.in_day     <= w.day;
        req_ch.in_month   <= w.month;
        req_ch.in_year    <= w.year;
        req_ch.day_offset <= w.offset;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(w);
        @(negedge clk);
    endtask

    task automatic drive_fields(int d, int m, int y, int off);
        date_req_t w;
        w.day    = d[DAY_W-1:0];
        w.month  = m[MONTH_W-1:0];
        w.year   = y[YEAR_W-1:0];
        w.offset = off[OFFSET_W-1:0];
        drive_word(w);
    endtask

    task automatic idle_sender(int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    task automatic apb_write(logic [2:0] idx, logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.write_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(logic [APB_DW-1:0] lo, logic [APB_DW-1:0] hi,
                                 logic [APB_DW-1:0] tday, logic [APB_DW-1:0] tmonth,
                                 logic [APB_DW-1:0] tyear);
        drain();
        apb_write(REG_MIN_YEAR, lo);
        apb_write(REG_MAX_YEAR, hi);
        apb_write(REG_TODAY_DAY, tday);
        apb_write(REG_TODAY_MONTH, tmonth);
        apb_write(REG_TODAY_YEAR, tyear);
    endtask

    // Random limits, junk in the unused upper bits of each write
    task automatic load_random_settings();
        int lo, hi;
        lo = $urandom_range(1, 9999);
        if ($urandom_range(0, 4) == 0)
            hi = $urandom_range(1, 9999);
        else
            hi = (lo + $urandom_range(0, 400) > 9999) ? 9999 : lo + $urandom_range(0, 400);
        load_settings(lo | ($urandom << YEAR_W), hi | ($urandom << YEAR_W),
                      $urandom, $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Random words: mostly well-formed dates within or near the year limits
    // ------------------------------------------------------------------------
    function automatic date_req_t random_request();
        date_req_t w;
        int        lo, hi, yr, tmp;
        lo = int'(board.min_year);
        hi = int'(board.max_year);
        if (lo > hi)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        if ($urandom_range(0, 99) < 15)
        begin
            w.day    = DAY_W'($urandom);
            w.month  = MONTH_W'($urandom);
            w.year   = YEAR_W'($urandom);
            w.offset = OFFSET_W'($urandom);
            return w;
        end
        w.month = MONTH_W'($urandom_range(1, 12));
        w.day   = DAY_W'($urandom_range(1, MONTH_DAYS[int'(w.month) - 1]));
        if ($urandom_range(0, 9) == 0)
        begin
            w.day   = DAY_W'(29);
            w.month = MONTH_W'(2);
        end
        case ($urandom_range(0, 3))
            0:       yr = lo - 2 + int'($urandom_range(0, 4));
            1:       yr = hi - 2 + int'($urandom_range(0, 4));
            default: yr = lo + int'($urandom_range(0, hi - lo));
        endcase
        if (yr < 0)
            yr = 0;
        if (yr > YEAR_TOP)
            yr = YEAR_TOP;
        w.year = yr[YEAR_W-1:0];
        case ($urandom_range(0, 9))
            0:       tmp = ($urandom_range(0, 1) != 0) ? 65535 : -65536;
            1, 2, 3: tmp = int'($urandom_range(0, 800)) - 400;
            4, 5, 6: tmp = int'($urandom_range(0, 80000)) - 40000;
            default: tmp = int'($urandom);
        endcase
        w.offset = tmp[OFFSET_W-1:0];
        // zero fields pick up today's date
        if ($urandom_range(0, 9) == 0)
            w.day = '0;
        if ($urandom_range(0, 9) == 0)
            w.month = '0;
        if ($urandom_range(0, 9) == 0)
            w.year = '0;
        return w;
    endfunction

    // Bursts of back-to-back words with random gaps; optional long output hold
    task automatic run_random(int count, bit hold);
        int burst_left, sent;
        burst_left = $urandom_range(1, 40);
        for (sent = 0; sent < count; sent++)
        begin
            if (hold && sent == count / 3)
                hold_off_cycles = HOLD_CYCLES;
            if (burst_left == 0)
            begin
                idle_sender($urandom_range(1, 10));
                burst_left = $urandom_range(1, 40);
            end
            drive_word(random_request());
            burst_left--;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready follows a rotating pattern, or a long hold
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] ready_pattern;
        int          pos;
        int          pattern_left;
        rsp_ch.ready  = 1'b0;
        ready_pattern = 16'hFFFF;
        pos           = 0;
        pattern_left  = 0;
        forever
        begin
            @(negedge clk);
            if (pattern_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    ready_pattern = 16'hFFFF;
                else
                    ready_pattern = 16'($urandom) | 16'h0101;
                pattern_left = $urandom_range(32, 200);
            end
            pattern_left--;
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ready_pattern[pos];
            pos = (pos + 1) % 16;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        date_rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.day    = rsp_ch.out_day;
            got.month  = rsp_ch.out_month;
            got.year   = rsp_ch.out_year;
            got.status = status_t'(rsp_ch.status);
            board.check_result(got);
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.in_day     = '0;
        req_ch.in_month   = '0;
        req_ch.in_year    = '0;
        req_ch.day_offset = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: 1902..2037, today 2024-01-01
        drive_fields(0, 0, 0, 0);
        drive_fields(0, 0, 0, 65535);
        drive_fields(0, 0, 0, -65536);
        drive_fields(31, 12, 2037, 0);
        drive_fields(31, 12, 2037, 1);
        drive_fields(1, 1, 1902, 0);
        drive_fields(1, 1, 1902, -1);
        drive_fields(31, 12, 2036, 1);
        drive_fields(28, 2, 2023, 1);
        drive_fields(29, 2, 2024, 0);
        drive_fields(29, 2, 2023, 0);
        drive_fields(29, 2, 2000, 365);
        drive_fields(29, 2, 2100, 0);
        drive_fields(31, 4, 2020, 0);
        drive_fields(30, 2, 2020, 0);
        drive_fields(0, 2, 2020, 10);
        drive_fields(31, 0, 2020, 0);
        drive_fields(1, 13, 2020, 0);
        drive_fields(31, 15, 2020, 0);
        drive_fields(0, 13, 0, 0);
        drive_fields(1, 1, 1901, 0);
        drive_fields(15, 6, 1990, -30000);
        drive_fields(31, 1, 16383, 0);
        run_random(190, 1'b1);

        // Limits 1..9999, today at the top of the range
        load_settings(1, 9999, 31, 12, 9999);
        run_random(190, 1'b0);

        // Year 0 allowed, upper limit from an all-ones write, today 0000-02-29
        load_settings(0, 32'hFFFF_FFFF, 29, 2, 0);
        drive_fields(0, 0, 0, 0);
        drive_fields(0, 0, 0, -1);
        drive_fields(0, 0, 0, -60);
        drive_fields(29, 2, 1900, 0);
        drive_fields(29, 2, 2000, 0);
        drive_fields(31, 12, 16383, 1);
        drive_fields(1, 1, 1, -1);
        run_random(190, 1'b1);

        // Inverted limits, today month out of range; writes past the last register
        load_settings(2000, 1999, 15, 13, 2000);
        apb_write(3'(NUM_REGS), $urandom);
        apb_write(3'(NUM_REGS + 1), $urandom);
        apb_write(3'(NUM_REGS + 2), $urandom);
        run_random(180, 1'b0);

        // Single-year window, today zero day and month
        load_settings(1900, 1900, 0, 0, 1900);
        run_random(180, 1'b0);

        // Today 1900-02-29 in a non-leap year
        load_settings(1582, 2500, 29, 2, 1900);
        run_random(190, 1'b1);

        load_random_settings();
        run_random(190, 1'b0);

        load_random_settings();
        run_random(190, 1'b1);

        // Only the year 9999
        load_settings(9999, 9999, 31, 1, 9999);
        run_random(60, 1'b0);

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
